// ===== rtl/core/plux_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plux_pkg
// Shared widths, register codes, configuration bundle and table helper for the
// piecewise lux block.
// ----------------------------------------------------------------------------
package plux_pkg;

  localparam int CHANNEL_SHIFT_DEF = 10;
  localparam int RATIO_SHIFT_DEF   = 9;
  localparam int LUX_SHIFT_DEF     = 14;

  localparam int COUNT_W  = 16;
  localparam int SCALE_W  = 20;
  localparam int ENTRY_W  = 16;
  localparam int SEG_N    = 8;
  localparam int TABLE_W  = ENTRY_W * SEG_N;
  localparam int IN_W     = 2 * COUNT_W;
  localparam int LUX_W    = 29;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 6;

  localparam logic [LUX_W-1:0] SAT_LUX = 29'd65536;
  localparam logic [LUX_W-1:0] LUX_MAX = 29'd268435456;

  localparam logic [COUNT_W-1:0] CLIP_RST  = 16'd4900;
  localparam logic [SCALE_W-1:0] SCALE_RST = 20'd479600;

  localparam logic [2:0] REG_CLIP      = 3'd0;
  localparam logic [2:0] REG_SCALE     = 3'd1;
  localparam logic [2:0] REG_BP_LO     = 3'd2;
  localparam logic [2:0] REG_BP_HI     = 3'd3;
  localparam logic [2:0] REG_OFFS_LO   = 3'd4;
  localparam logic [2:0] REG_OFFS_HI   = 3'd5;
  localparam logic [2:0] REG_SLOPES_LO = 3'd6;
  localparam logic [2:0] REG_SLOPES_HI = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0] clip;
    logic [SCALE_W-1:0] scale;
    logic [TABLE_W-1:0] bp;
    logic [TABLE_W-1:0] offs;
    logic [TABLE_W-1:0] slopes;
  } plux_cfg_t;

  // entry k of a table packed as eight 16-bit fields, entry 0 in the low bits
  function automatic logic [ENTRY_W-1:0] entry16(input logic [TABLE_W-1:0] tbl,
                                                 input logic [2:0] k);
    return tbl[{k, 4'b0000} +: ENTRY_W];
  endfunction

endpackage

// ===== rtl/core/plux_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plux_regs
// APB register file holding clip level, channel scale and the segment tables.
// ----------------------------------------------------------------------------
module plux_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plux_pkg::APB_AW-1:0] paddr,
  input  logic [plux_pkg::APB_DW-1:0] pwdata,
  output logic [plux_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output plux_pkg::plux_cfg_t         cfg
);
  import plux_pkg::*;

  logic [COUNT_W-1:0] clip_r;
  logic [SCALE_W-1:0] scale_r;
  logic [APB_DW-1:0]  bp_lo_r, bp_hi_r, offs_lo_r, offs_hi_r, slopes_lo_r, slopes_hi_r;
  logic [2:0]         idx;
  logic               wr_en;

  assign idx    = paddr[APB_AW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r      <= CLIP_RST;
      scale_r     <= SCALE_RST;
      bp_lo_r     <= '0;
      bp_hi_r     <= '0;
      offs_lo_r   <= '0;
      offs_hi_r   <= '0;
      slopes_lo_r <= '0;
      slopes_hi_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CLIP:      clip_r      <= pwdata[COUNT_W-1:0];
        REG_SCALE:     scale_r     <= pwdata[SCALE_W-1:0];
        REG_BP_LO:     bp_lo_r     <= pwdata;
        REG_BP_HI:     bp_hi_r     <= pwdata;
        REG_OFFS_LO:   offs_lo_r   <= pwdata;
        REG_OFFS_HI:   offs_hi_r   <= pwdata;
        REG_SLOPES_LO: slopes_lo_r <= pwdata;
        REG_SLOPES_HI: slopes_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLIP:      prdata = {{(APB_DW-COUNT_W){1'b0}}, clip_r};
      REG_SCALE:     prdata = {{(APB_DW-SCALE_W){1'b0}}, scale_r};
      REG_BP_LO:     prdata = bp_lo_r;
      REG_BP_HI:     prdata = bp_hi_r;
      REG_OFFS_LO:   prdata = offs_lo_r;
      REG_OFFS_HI:   prdata = offs_hi_r;
      REG_SLOPES_LO: prdata = slopes_lo_r;
      REG_SLOPES_HI: prdata = slopes_hi_r;
      default:       prdata = '0;
    endcase
  end

  assign cfg.clip   = clip_r;
  assign cfg.scale  = scale_r;
  assign cfg.bp     = {bp_hi_r, bp_lo_r};
  assign cfg.offs   = {offs_hi_r, offs_lo_r};
  assign cfg.slopes = {slopes_hi_r, slopes_lo_r};

endmodule

// ===== rtl/core/plux_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plux_scale
// First stage: clip check and scaling of both channels by the gain factor.
// ----------------------------------------------------------------------------
module plux_scale #(
  parameter int CHANNEL_SHIFT = plux_pkg::CHANNEL_SHIFT_DEF,
  parameter int CW            = plux_pkg::COUNT_W + plux_pkg::SCALE_W - CHANNEL_SHIFT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      v_in,
  input  logic [plux_pkg::IN_W-1:0] counts,
  input  plux_pkg::plux_cfg_t       cfg,
  output logic                      v_r,
  output logic                      sat_r,
  output logic [CW-1:0]             ch0_r,
  output logic [CW-1:0]             ch1_r
);
  import plux_pkg::*;

  localparam int PW = COUNT_W + SCALE_W;

  logic [COUNT_W-1:0] bb, ir;
  logic [PW-1:0]      prod0, prod1;
  logic               sat;

  assign bb    = counts[IN_W-1:COUNT_W];
  assign ir    = counts[COUNT_W-1:0];
  assign sat   = (bb > cfg.clip) || (ir > cfg.clip);
  assign prod0 = PW'(bb) * PW'(cfg.scale);
  assign prod1 = PW'(ir) * PW'(cfg.scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat;
      ch0_r <= prod0[PW-1:CHANNEL_SHIFT];
      ch1_r <= prod1[PW-1:CHANNEL_SHIFT];
    end
  end

endmodule

// ===== rtl/core/plux_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plux_div
// Pipelined restoring divider, one quotient bit per stage, forming
// (ch1 << (RATIO_SHIFT+1)) / ch0 while carrying the channel values along.
// ----------------------------------------------------------------------------
module plux_div #(
  parameter int CW          = 26,
  parameter int RATIO_SHIFT = plux_pkg::RATIO_SHIFT_DEF,
  parameter int NW          = CW + RATIO_SHIFT + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic          sat_in,
  input  logic [CW-1:0] ch0_in,
  input  logic [CW-1:0] ch1_in,
  output logic          v_out,
  output logic          sat_out,
  output logic [CW-1:0] ch0_out,
  output logic [CW-1:0] ch1_out,
  output logic [NW-1:0] quot_out
);

  logic          v_r     [NW];
  logic          sat_r   [NW];
  logic [CW-1:0] ch0_r   [NW];
  logic [CW-1:0] ch1_r   [NW];
  logic [CW-1:0] rem_r   [NW];
  logic [NW-1:0] q_r     [NW];
  logic          v_nxt   [NW];
  logic          sat_nxt [NW];
  logic [CW-1:0] ch0_nxt [NW];
  logic [CW-1:0] ch1_nxt [NW];
  logic [CW-1:0] rem_nxt [NW];
  logic [NW-1:0] q_nxt   [NW];

  always_comb begin
    logic [CW-1:0] pc0, pc1, prem;
    logic [NW-1:0] pq, num;
    logic [CW:0]   rsh, rsub;
    logic          take;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        v_nxt[s]   = v_in;
        sat_nxt[s] = sat_in;
        pc0        = ch0_in;
        pc1        = ch1_in;
        prem       = '0;
        pq         = '0;
      end else begin
        v_nxt[s]   = v_r[s-1];
        sat_nxt[s] = sat_r[s-1];
        pc0        = ch0_r[s-1];
        pc1        = ch1_r[s-1];
        prem       = rem_r[s-1];
        pq         = q_r[s-1];
      end
      num  = {pc1, {(RATIO_SHIFT+1){1'b0}}};
      // bring down the next numerator bit, msb first
      rsh  = {prem, num[NW-1-s]};
      take = rsh >= {1'b0, pc0};
      rsub = rsh - {1'b0, pc0};
      ch0_nxt[s] = pc0;
      ch1_nxt[s] = pc1;
      rem_nxt[s] = take ? rsub[CW-1:0] : rsh[CW-1:0];
      q_nxt[s]   = {pq[NW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NW; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat_nxt;
      ch0_r <= ch0_nxt;
      ch1_r <= ch1_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign v_out    = v_r[NW-1];
  assign sat_out  = sat_r[NW-1];
  assign ch0_out  = ch0_r[NW-1];
  assign ch1_out  = ch1_r[NW-1];
  assign quot_out = q_r[NW-1];

endmodule

// ===== rtl/core/plux_lux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plux_lux
// Back end: ratio rounding and segment pick, coefficient multiply,
// clamped difference, then rounding shift into the output register.
// ----------------------------------------------------------------------------
module plux_lux #(
  parameter int CW        = 26,
  parameter int NW        = 36,
  parameter int LUX_SHIFT = plux_pkg::LUX_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_in,
  input  logic                       sat_in,
  input  logic [CW-1:0]              ch0_in,
  input  logic [CW-1:0]              ch1_in,
  input  logic [NW-1:0]              quot_in,
  input  plux_pkg::plux_cfg_t        cfg,
  output logic                       out_valid,
  output logic [plux_pkg::LUX_W-1:0] out_lux,
  output logic                       out_saturated
);
  import plux_pkg::*;

  localparam int PW = CW + ENTRY_W;
  localparam int SW = PW + 1 - LUX_SHIFT;
  localparam int MW = (SW > LUX_W) ? SW : LUX_W;
  localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (LUX_SHIFT - 1);

  // stage a: segment select
  logic [NW-1:0]      qz;
  logic [NW:0]        qinc;
  logic [NW-1:0]      ratio;
  logic [2:0]         seg;
  logic               va_r, sata_r;
  logic [CW-1:0]      ch0a_r, ch1a_r;
  logic [ENTRY_W-1:0] off_r, slope_r;

  assign qz    = (ch0_in == '0) ? '0 : quot_in;
  assign qinc  = {1'b0, qz} + {{NW{1'b0}}, 1'b1};
  assign ratio = qinc[NW:1];

  always_comb begin
    seg = 3'd7;
    for (int k = SEG_N - 2; k >= 0; k--) begin
      if (ratio <= {{(NW-ENTRY_W){1'b0}}, entry16(cfg.bp, 3'(k))}) begin
        seg = 3'(k);
      end
    end
  end

  // stage b: coefficient products
  logic          vb_r, satb_r;
  logic [PW-1:0] a_r, b_r;

  // stage c: clamped difference
  logic          vc_r, satc_r;
  logic [PW-1:0] diff_r;

  // stage d: rounding shift and saturation
  logic [PW:0]        rnd;
  logic [SW-1:0]      shifted;
  logic [MW-1:0]      sh_ext;
  logic [LUX_W-1:0]   lux_val;

  assign rnd     = {1'b0, diff_r} + HALF;
  assign shifted = rnd[PW:LUX_SHIFT];
  assign sh_ext  = MW'(shifted);
  assign lux_val = (sh_ext > MW'(LUX_MAX)) ? LUX_MAX : sh_ext[LUX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va_r      <= v_in;
      vb_r      <= va_r;
      vc_r      <= vb_r;
      out_valid <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sata_r        <= sat_in;
      ch0a_r        <= ch0_in;
      ch1a_r        <= ch1_in;
      off_r         <= entry16(cfg.offs, seg);
      slope_r       <= entry16(cfg.slopes, seg);
      satb_r        <= sata_r;
      a_r           <= PW'(ch0a_r) * PW'(off_r);
      b_r           <= PW'(ch1a_r) * PW'(slope_r);
      satc_r        <= satb_r;
      diff_r        <= (a_r > b_r) ? (a_r - b_r) : '0;
      out_saturated <= satc_r;
      out_lux       <= satc_r ? SAT_LUX : lux_val;
    end
  end

endmodule

// ===== rtl/core/piecewise_lux_from_two_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_lux_from_two_channels
// Lux estimate from a broadband and an infrared count, piecewise linear in
// the infrared to broadband ratio.
// ----------------------------------------------------------------------------
// Input channel: in_channel_counts carries broadband in bits 31:16 and
// infrared in bits 15:0, transferred on in_valid && in_ready. Result channel:
// out_lux and out_saturated, transferred on out_valid && out_ready. Every
// input transfer yields exactly one result, in order.
// The quotient is NW = 36 - CHANNEL_SHIFT + RATIO_SHIFT + 1 bits wide. The
// pipeline is one scaling stage, one divider stage per quotient bit, then
// segment pick, multiply, difference and output register.
// Throughput is one sample per cycle while the receiver does not stall; the
// bit-serial divider pipeline sets the depth, not the rate.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// bubbles included, and in_ready drops until the result is taken.
// Configuration is written over the APB port at byte address 8*index, only
// while no sample is in flight: the user must ensure it, the block does not.
// Synchronous reset empties the pipe, sets clip 4900, scale 479600, tables 0.
// ----------------------------------------------------------------------------
module piecewise_lux_from_two_channels #(
  parameter int CHANNEL_SHIFT = plux_pkg::CHANNEL_SHIFT_DEF,
  parameter int RATIO_SHIFT   = plux_pkg::RATIO_SHIFT_DEF,
  parameter int LUX_SHIFT     = plux_pkg::LUX_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [plux_pkg::IN_W-1:0]   in_channel_counts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plux_pkg::LUX_W-1:0]  out_lux,
  output logic                        out_saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plux_pkg::APB_AW-1:0] paddr,
  input  logic [plux_pkg::APB_DW-1:0] pwdata,
  output logic [plux_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import plux_pkg::*;

  localparam int CW = COUNT_W + SCALE_W - CHANNEL_SHIFT;
  localparam int NW = CW + RATIO_SHIFT + 1;

  plux_cfg_t     cfg;
  logic          en;
  logic          s1_v, s1_sat;
  logic [CW-1:0] s1_ch0, s1_ch1;
  logic          d_v, d_sat;
  logic [CW-1:0] d_ch0, d_ch1;
  logic [NW-1:0] d_quot;

  // the pipe moves as one unless a finished result is held at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  plux_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plux_scale #(
    .CHANNEL_SHIFT (CHANNEL_SHIFT),
    .CW            (CW)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_in   (in_valid),
    .counts (in_channel_counts),
    .cfg    (cfg),
    .v_r    (s1_v),
    .sat_r  (s1_sat),
    .ch0_r  (s1_ch0),
    .ch1_r  (s1_ch1)
  );

  plux_div #(
    .CW          (CW),
    .RATIO_SHIFT (RATIO_SHIFT),
    .NW          (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (s1_v),
    .sat_in   (s1_sat),
    .ch0_in   (s1_ch0),
    .ch1_in   (s1_ch1),
    .v_out    (d_v),
    .sat_out  (d_sat),
    .ch0_out  (d_ch0),
    .ch1_out  (d_ch1),
    .quot_out (d_quot)
  );

  plux_lux #(
    .CW        (CW),
    .NW        (NW),
    .LUX_SHIFT (LUX_SHIFT)
  ) u_lux (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .v_in          (d_v),
    .sat_in        (d_sat),
    .ch0_in        (d_ch0),
    .ch1_in        (d_ch1),
    .quot_in       (d_quot),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_lux       (out_lux),
    .out_saturated (out_saturated)
  );

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_lux == SAT_LUX)
    else $error("saturated result without the saturation lux value");

  a_lux_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lux <= LUX_MAX)
    else $error("lux result above its ceiling");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the pipeline is stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lux) && $stable(out_saturated))
    else $error("held result changed during a stall");

endmodule
